// ----- rtl/flow_endpoint_demux_table_macros.svh -----
// Assertion macros shared by the demux table modules.
`ifndef FLOW_ENDPOINT_DEMUX_TABLE_MACROS_SVH
`define FLOW_ENDPOINT_DEMUX_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FDT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FDT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fdt_pkg.sv -----
// Shared types and codes for the flow endpoint demux table.
`timescale 1ns / 1ps
`default_nettype none
package fdt_pkg;

  typedef enum logic [2:0] {
    OP_LOOKUP     = 3'd0,
    OP_ALLOC_EPH  = 3'd1,
    OP_ALLOC_PORT = 3'd2,
    OP_FREE_PORT  = 3'd3,
    OP_ALLOC_FLOW = 3'd4,
    OP_FREE_FLOW  = 3'd5,
    OP_SET_RX     = 3'd6,
    OP_UNUSED     = 3'd7
  } op_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MISS      = 3'd1;
  localparam logic [2:0] ST_DUP       = 3'd2;
  localparam logic [2:0] ST_EXHAUSTED = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_FLOW     = 2'd1;
  localparam logic [1:0] KIND_LISTENER = 2'd2;

  localparam logic CFG_PORT_FIRST = 1'b0;
  localparam logic CFG_PORT_LAST  = 1'b1;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 48;

  typedef struct packed {
    op_t         op;
    logic [15:0] lport;
    logic [31:0] addr;
    logic [15:0] sport;
    logic [15:0] peer;
    logic        to_flow;
    logic        rx;
  } req_t;

endpackage
`default_nettype wire

// ----- rtl/fdt_front.sv -----
// Front end: accepts request transactions, decodes them and queues them.
`timescale 1ns / 1ps
`default_nettype none
`include "flow_endpoint_demux_table_macros.svh"
module fdt_front import fdt_pkg::*; #(
  parameter int PORT_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic [2:0]           in_tuser,
  output logic                      q_valid,
  input  wire logic                 q_ready,
  output req_t                      q_req
);

  localparam int QDEPTH = 2;
  localparam logic [15:0] PORT_MASK =
    (PORT_BITS >= 16) ? 16'hffff : 16'((32'd1 << PORT_BITS) - 32'd1);

  req_t       mem_r [QDEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  req_t       dec;
  logic       push, pop;

  always_comb begin
    dec.op      = op_t'(in_tuser);
    dec.lport   = in_tdata[15:0] & PORT_MASK;
    dec.addr    = in_tdata[47:16];
    dec.sport   = in_tdata[63:48];
    dec.peer    = in_tdata[79:64];
    dec.to_flow = in_tdata[80];
    dec.rx      = in_tdata[81];
  end

  assign in_tready = (cnt_r != 2'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_req     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  `FDT_ASSERT_IMP(a_q_level, clk, rst_n, 1'b1, cnt_r <= 2'(QDEPTH), "queue overfilled")

endmodule
`default_nettype wire

// ----- rtl/fdt_back.sv -----
// Back end: listener and flow tables, request execution and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "flow_endpoint_demux_table_macros.svh"
module fdt_back import fdt_pkg::*; #(
  parameter int LISTENER_ENTRIES = 64,
  parameter int FLOW_ENTRIES     = 64,
  parameter int PORT_BITS        = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  req_t             q_req,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [1:0]       out_kind,
  output logic [5:0]       out_index,
  output logic [15:0]      out_lport,
  output logic [15:0]      out_pport
);

  localparam int LW = $clog2(LISTENER_ENTRIES);
  localparam int FW = $clog2(FLOW_ENTRIES);
  localparam logic [15:0] PORT_MASK =
    (PORT_BITS >= 16) ? 16'hffff : 16'((32'd1 << PORT_BITS) - 32'd1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_RES  = 5'b00100,
    S_EPH  = 5'b01000,
    S_ECHK = 5'b10000
  } st_t;

  st_t st_r, st_nxt;
  req_t req_r;

  logic        lv_r   [LISTENER_ENTRIES];
  logic [15:0] lport_r[LISTENER_ENTRIES];
  logic [15:0] lpeer_r[LISTENER_ENTRIES];
  logic        lrx_r  [LISTENER_ENTRIES];
  logic        fv_r   [FLOW_ENTRIES];
  logic [15:0] fdp_r  [FLOW_ENTRIES];
  logic [31:0] fsa_r  [FLOW_ENTRIES];
  logic [15:0] fsp_r  [FLOW_ENTRIES];
  logic        frx_r  [FLOW_ENTRIES];

  logic [LISTENER_ENTRIES-1:0] lhit_r;
  logic [FLOW_ENTRIES-1:0]     fhit_r;
  logic [LISTENER_ENTRIES-1:0] chit;

  logic [15:0] port_first_r, port_last_r, cursor_r;
  logic [16:0] cand_r, cand_nxt, tries_r, tries_nxt, cand_inc;
  logic [LW-1:0] slot_r, slot_nxt;

  logic [LW-1:0] l_idx, lf_idx;
  logic [FW-1:0] f_idx, ff_idx;
  logic          l_found, lf_found, f_found, ff_found, c_any;

  // Table write controls
  logic          lw_en, lclr_en, lrx_en, fw_en, fclr_en, frx_en, cur_en;
  logic [LW-1:0] lw_idx, lclr_idx, lrx_idx;
  logic [FW-1:0] fw_idx, fclr_idx, frx_idx;
  logic [15:0]   lw_port;

  // Result load
  logic        res_load;
  logic [2:0]  res_status;
  logic [1:0]  res_kind;
  logic [5:0]  res_idx;
  logic [15:0] res_lp, res_pp;

  logic        out_valid_r;
  logic [2:0]  status_r;
  logic [1:0]  kind_r;
  logic [5:0]  idx_r;
  logic [15:0] olp_r, opp_r;

  // Lowest matching and lowest free entries; stored keys are unique, so this only breaks ties.
  always_comb begin
    l_idx = '0; l_found = 1'b0; lf_idx = '0; lf_found = 1'b0;
    for (int i = LISTENER_ENTRIES - 1; i >= 0; i--) begin
      if (lhit_r[i]) begin
        l_idx = LW'(i); l_found = 1'b1;
      end
      if (!lv_r[i]) begin
        lf_idx = LW'(i); lf_found = 1'b1;
      end
    end
  end

  always_comb begin
    f_idx = '0; f_found = 1'b0; ff_idx = '0; ff_found = 1'b0;
    for (int i = FLOW_ENTRIES - 1; i >= 0; i--) begin
      if (fhit_r[i]) begin
        f_idx = FW'(i); f_found = 1'b1;
      end
      if (!fv_r[i]) begin
        ff_idx = FW'(i); ff_found = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LISTENER_ENTRIES; i++) begin
      chit[i] = lv_r[i] && (lport_r[i] == cand_r[15:0]);
    end
  end
  assign c_any = |chit;

  assign q_ready  = (st_r == S_IDLE) && (!out_valid_r || out_ready);
  assign cand_inc = cand_r + 17'd1;

  always_comb begin
    st_nxt     = st_r;
    cand_nxt   = cand_r;
    tries_nxt  = tries_r;
    slot_nxt   = slot_r;
    lw_en = 1'b0; lclr_en = 1'b0; lrx_en = 1'b0;
    fw_en = 1'b0; fclr_en = 1'b0; frx_en = 1'b0; cur_en = 1'b0;
    lw_idx = lf_idx; lclr_idx = l_idx; lrx_idx = l_idx;
    fw_idx = ff_idx; fclr_idx = f_idx; frx_idx = f_idx;
    lw_port    = req_r.lport;
    res_load   = 1'b0;
    res_status = ST_MISS;
    res_kind   = KIND_NONE;
    res_idx    = '0;
    res_lp     = '0;
    res_pp     = '0;
    case (st_r)
      S_IDLE: begin
        if (q_valid && q_ready) st_nxt = S_CMP;
      end
      S_CMP: st_nxt = S_RES;
      S_RES: begin
        st_nxt   = S_IDLE;
        res_load = 1'b1;
        case (req_r.op)
          OP_LOOKUP: begin
            if (f_found && frx_r[f_idx]) begin
              res_status = ST_OK; res_kind = KIND_FLOW; res_idx = 6'(f_idx);
              res_lp = fdp_r[f_idx]; res_pp = fsp_r[f_idx];
            end else if (l_found && lrx_r[l_idx]) begin
              res_status = ST_OK; res_kind = KIND_LISTENER; res_idx = 6'(l_idx);
              res_lp = lport_r[l_idx]; res_pp = lpeer_r[l_idx];
            end
          end
          OP_ALLOC_EPH: begin
            if (!lf_found) begin
              res_status = ST_FULL;
            end else if (port_first_r > port_last_r) begin
              res_status = ST_EXHAUSTED;
            end else begin
              res_load  = 1'b0;
              st_nxt    = S_EPH;
              slot_nxt  = lf_idx;
              cand_nxt  = {1'b0, cursor_r};
              tries_nxt = {1'b0, port_last_r} - {1'b0, port_first_r} + 17'd1;
            end
          end
          OP_ALLOC_PORT: begin
            if (l_found) begin
              res_status = ST_DUP; res_kind = KIND_LISTENER; res_idx = 6'(l_idx);
              res_lp = lport_r[l_idx]; res_pp = lpeer_r[l_idx];
            end else if (!lf_found) begin
              res_status = ST_FULL;
            end else begin
              lw_en = 1'b1;
              res_status = ST_OK; res_kind = KIND_LISTENER; res_idx = 6'(lf_idx);
              res_lp = req_r.lport; res_pp = req_r.peer;
            end
          end
          OP_FREE_PORT: begin
            if (l_found) begin
              lclr_en = 1'b1;
              res_status = ST_OK; res_kind = KIND_LISTENER; res_idx = 6'(l_idx);
              res_lp = lport_r[l_idx]; res_pp = lpeer_r[l_idx];
            end else begin
              res_status = ST_NOT_FOUND;
            end
          end
          OP_ALLOC_FLOW: begin
            if (f_found) begin
              res_status = ST_OK; res_kind = KIND_FLOW; res_idx = 6'(f_idx);
              res_lp = fdp_r[f_idx]; res_pp = fsp_r[f_idx];
            end else if (!ff_found) begin
              res_status = ST_FULL;
            end else begin
              fw_en = 1'b1;
              res_status = ST_OK; res_kind = KIND_FLOW; res_idx = 6'(ff_idx);
              res_lp = req_r.lport; res_pp = req_r.sport;
            end
          end
          OP_FREE_FLOW: begin
            if (f_found) begin
              fclr_en = 1'b1;
              res_status = ST_OK; res_kind = KIND_FLOW; res_idx = 6'(f_idx);
              res_lp = fdp_r[f_idx]; res_pp = fsp_r[f_idx];
            end else begin
              res_status = ST_NOT_FOUND;
            end
          end
          OP_SET_RX: begin
            if (req_r.to_flow) begin
              if (f_found) begin
                frx_en = 1'b1;
                res_status = ST_OK; res_kind = KIND_FLOW; res_idx = 6'(f_idx);
                res_lp = fdp_r[f_idx]; res_pp = fsp_r[f_idx];
              end else begin
                res_status = ST_NOT_FOUND;
              end
            end else if (l_found) begin
              lrx_en = 1'b1;
              res_status = ST_OK; res_kind = KIND_LISTENER; res_idx = 6'(l_idx);
              res_lp = lport_r[l_idx]; res_pp = lpeer_r[l_idx];
            end else begin
              res_status = ST_NOT_FOUND;
            end
          end
          default: res_status = ST_MISS;
        endcase
      end
      S_EPH: begin
        // Step to the next candidate; passing port_last or running out of tries ends the search.
        if (tries_r == 17'd0 || cand_inc > {1'b0, port_last_r}) begin
          res_load   = 1'b1;
          res_status = ST_EXHAUSTED;
          st_nxt     = S_IDLE;
        end else begin
          cand_nxt  = (cand_inc < {1'b0, port_first_r}) ? {1'b0, port_first_r} : cand_inc;
          tries_nxt = tries_r - 17'd1;
          st_nxt    = S_ECHK;
        end
      end
      S_ECHK: begin
        if (!c_any) begin
          lw_en      = 1'b1;
          lw_idx     = slot_r;
          lw_port    = cand_r[15:0];
          cur_en     = 1'b1;
          res_load   = 1'b1;
          res_status = ST_OK;
          res_kind   = KIND_LISTENER;
          res_idx    = 6'(slot_r);
          res_lp     = cand_r[15:0];
          res_pp     = req_r.peer;
          st_nxt     = S_IDLE;
        end else begin
          st_nxt = S_EPH;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) req_r <= q_req;
    if (st_r == S_CMP) begin
      for (int i = 0; i < LISTENER_ENTRIES; i++) begin
        lhit_r[i] <= lv_r[i] && (lport_r[i] == req_r.lport);
      end
      for (int i = 0; i < FLOW_ENTRIES; i++) begin
        fhit_r[i] <= fv_r[i] && (fdp_r[i] == req_r.lport) &&
                     (fsa_r[i] == req_r.addr) && (fsp_r[i] == req_r.sport);
      end
    end
    cand_r  <= cand_nxt;
    tries_r <= tries_nxt;
    slot_r  <= slot_nxt;
    if (lw_en) begin
      lport_r[lw_idx] <= lw_port;
      lpeer_r[lw_idx] <= req_r.peer;
    end
    if (lw_en) lrx_r[lw_idx] <= 1'b1;
    else if (lrx_en) lrx_r[lrx_idx] <= req_r.rx;
    if (fw_en) begin
      fdp_r[fw_idx] <= req_r.lport;
      fsa_r[fw_idx] <= req_r.addr;
      fsp_r[fw_idx] <= req_r.sport;
    end
    if (fw_en) frx_r[fw_idx] <= 1'b1;
    else if (frx_en) frx_r[frx_idx] <= req_r.rx;
    if (res_load) begin
      status_r <= res_status;
      kind_r   <= res_kind;
      idx_r    <= res_idx;
      olp_r    <= res_lp;
      opp_r    <= res_pp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      out_valid_r  <= 1'b0;
      port_first_r <= 16'd1 & PORT_MASK;
      port_last_r  <= 16'hffff & PORT_MASK;
      cursor_r     <= 16'd1 & PORT_MASK;
      for (int i = 0; i < LISTENER_ENTRIES; i++) lv_r[i] <= 1'b0;
      for (int i = 0; i < FLOW_ENTRIES; i++) fv_r[i] <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (res_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (lw_en) lv_r[lw_idx] <= 1'b1;
      if (lclr_en) lv_r[lclr_idx] <= 1'b0;
      if (fw_en) fv_r[fw_idx] <= 1'b1;
      if (fclr_en) fv_r[fclr_idx] <= 1'b0;
      if (cur_en) cursor_r <= cand_r[15:0];
      if (cfg_wr_en) begin
        if (cfg_index == CFG_PORT_FIRST) begin
          port_first_r <= cfg_wdata & PORT_MASK;
          cursor_r     <= cfg_wdata & PORT_MASK;
        end else begin
          port_last_r <= cfg_wdata & PORT_MASK;
        end
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_kind   = kind_r;
  assign out_index  = idx_r;
  assign out_lport  = olp_r;
  assign out_pport  = opp_r;

  `FDT_ASSERT_IMP(a_cand_range, clk, rst_n, st_r == S_ECHK, (cand_r >= 17'(port_first_r)) && (cand_r <= 17'(port_last_r)), "candidate outside port range")
  `FDT_ASSERT_IMP(a_no_overwrite, clk, rst_n, res_load, !out_valid_r || out_ready, "result overwritten")
  `FDT_ASSERT_NXT(a_pop_starts, clk, rst_n, q_valid && q_ready, st_r == S_CMP, "pop did not start compare")

endmodule
`default_nettype wire

// ----- rtl/flow_endpoint_demux_table.sv -----
// Top level of the flow endpoint demux table.
`timescale 1ns / 1ps
`default_nettype none
// Receive demultiplexer with a listener table keyed by local port and a flow table keyed
// by destination port, source address and source port. Requests pass through a two-entry
// queue into the execution unit, which handles one request at a time: pop, parallel key
// compare, then resolve and write, which loads the result into an output register.
// Ephemeral allocation steps candidate ports through S_EPH and S_ECHK, at most
// port_last - port_first + 1 of them; each candidate is checked against every listener
// entry in one compare, and a search that runs past port_last or out of tries ends in
// S_EPH with an exhausted result after its last candidate. Valid bits clear at
// reset; configuration may only be written while no request is in flight.
module flow_endpoint_demux_table import fdt_pkg::*; #(
  parameter int LISTENER_ENTRIES = 64,
  parameter int FLOW_ENTRIES     = 64,
  parameter int PORT_BITS        = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // local_port, src_addr, src_port, peer_port, target_is_flow, rx_enable, zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // operation
  input  wire logic [2:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // status, entry_index, result_local_port, result_peer_port, zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // hit_kind
  output logic [1:0]                 out_tuser,
  input  wire logic                  cfg_wr_en,
  input  wire logic                  cfg_index,
  input  wire logic [15:0]           cfg_wdata
);

  logic        q_valid, q_ready;
  req_t        q_req;
  logic [2:0]  status;
  logic [5:0]  index;
  logic [15:0] lport, pport;

  fdt_front #(.PORT_BITS(PORT_BITS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  fdt_back #(
    .LISTENER_ENTRIES(LISTENER_ENTRIES),
    .FLOW_ENTRIES(FLOW_ENTRIES),
    .PORT_BITS(PORT_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_status(status), .out_kind(out_tuser), .out_index(index),
    .out_lport(lport), .out_pport(pport)
  );

  assign out_tdata = {7'd0, pport, lport, index, status};

endmodule
`default_nettype wire
